[hdl/tws_pkg.sv]
// Shared types, constants and register codes for the two-wheel position sequencer.
package tws_pkg;

    // Command table geometry.
    localparam int COMMAND_DEPTH = 256;
    localparam int CMD_AW = (COMMAND_DEPTH > 1) ? $clog2(COMMAND_DEPTH) : 1;
    localparam int PTR_W  = $clog2(COMMAND_DEPTH + 1);
    localparam int CNT_W  = (PTR_W > 9) ? PTR_W : 9;
    localparam int IDX_W  = (CMD_AW > 8) ? CMD_AW : 8;

    // Configuration register indexes.
    localparam logic [2:0] REG_GAIN           = 3'd0;
    localparam logic [2:0] REG_BASE_PWM_RIGHT = 3'd1;
    localparam logic [2:0] REG_BASE_PWM_LEFT  = 3'd2;
    localparam logic [2:0] REG_SPEED_CAP      = 3'd3;
    localparam logic [2:0] REG_NUM_COMMANDS   = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [3:0]  GAIN_RST           = 4'd3;
    localparam logic [15:0] BASE_PWM_RIGHT_RST = 16'h0190;
    localparam logic [15:0] BASE_PWM_LEFT_RST  = 16'h0190 + 16'd12;
    localparam logic [15:0] SPEED_CAP_RST      = 16'h012C;
    localparam logic [8:0]  NUM_COMMANDS_RST   = 9'd0;

    // Motor direction codes.
    localparam logic [1:0] DIR_OFF     = 2'd0;
    localparam logic [1:0] DIR_FORWARD = 2'd1;
    localparam logic [1:0] DIR_REVERSE = 2'd2;

    // Input operation codes.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef struct packed {
        logic signed [31:0] delta_right;
        logic signed [31:0] delta_left;
        logic signed [15:0] vel_right;
        logic signed [15:0] vel_left;
    } cmd_entry_t;

    localparam int ENTRY_W = $bits(cmd_entry_t);

    // One wheel's work carried from the error stage to the drive stage.
    typedef struct packed {
        logic [32:0]        abs_err;
        logic [1:0]         dir;
        logic signed [15:0] speed;
    } wheel_err_t;

    typedef struct packed {
        logic [3:0]  gain;
        logic [15:0] speed_cap;
    } drive_cfg_t;

endpackage

[hdl/tws_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module tws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/tws_drive.sv]
// Drive stage of one wheel: saturated proportional magnitude and compare value.
module tws_drive (
    input  tws_pkg::wheel_err_t err,
    input  tws_pkg::drive_cfg_t cfg,
    input  logic [15:0]         base_pwm,
    output logic [15:0]         pwm
);
    import tws_pkg::*;

    logic [36:0] product;
    logic [15:0] range;
    logic [15:0] mag;

    always_comb begin
        product = 37'(err.abs_err) * 37'(cfg.gain);
        // A negative speed limit allows no drive at all.
        if (err.speed[15]) begin
            range = 16'd0;
        end else if (16'(err.speed) > cfg.speed_cap) begin
            range = cfg.speed_cap;
        end else begin
            range = 16'(err.speed);
        end
        if (product > 37'(range)) begin
            mag = range;
        end else begin
            mag = product[15:0];
        end
        pwm = base_pwm - mag;
    end

endmodule

[hdl/two_wheel_position_sequencer.sv]
// Top level of the two-wheel position sequencer: error stage, table sequencing, drive stage.
//
// A tick transfer gives one result through the error stage and result registers;
// loads give none. Ticks and loads are taken one per cycle while the result channel
// does not stall, except that a tick which steps to the next command entry is
// followed by a pause without a transfer while that entry is read from the registered
// command table memory and added to the targets. The error stage register lets a new
// transfer in while a finished result waits. Load entries are written in the cycle of
// their transfer; an entry must be loaded before the sequence reaches it.
module two_wheel_position_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic signed [31:0] s_position_right,
    input  logic signed [31:0] s_position_left,
    input  logic [7:0]  s_entry_index,
    input  logic signed [31:0] s_delta_right,
    input  logic signed [31:0] s_delta_left,
    input  logic signed [15:0] s_entry_speed_right,
    input  logic signed [15:0] s_entry_speed_left,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_pwm_right,
    output logic [15:0] m_pwm_left,
    output logic [1:0]  m_dir_right,
    output logic [1:0]  m_dir_left,
    output logic        m_sequence_done
);
    import tws_pkg::*;

    // Configuration registers.
    logic [3:0]  gain_reg;
    logic [15:0] base_right_reg;
    logic [15:0] base_left_reg;
    logic [15:0] speed_cap_reg;
    logic [8:0]  num_cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg       <= GAIN_RST;
            base_right_reg <= BASE_PWM_RIGHT_RST;
            base_left_reg  <= BASE_PWM_LEFT_RST;
            speed_cap_reg  <= SPEED_CAP_RST;
            num_cmd_reg    <= NUM_COMMANDS_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_GAIN:           gain_reg       <= cfg_wdata[3:0];
                REG_BASE_PWM_RIGHT: base_right_reg <= cfg_wdata;
                REG_BASE_PWM_LEFT:  base_left_reg  <= cfg_wdata;
                REG_SPEED_CAP:      speed_cap_reg  <= cfg_wdata;
                REG_NUM_COMMANDS:   num_cmd_reg    <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    // Sequencer state. ptr_reg holds the index of the next entry to take.
    logic signed [31:0] target_right_reg, target_right_next;
    logic signed [31:0] target_left_reg, target_left_next;
    logic signed [15:0] lim_right_reg, lim_right_next;
    logic signed [15:0] lim_left_reg, lim_left_next;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic               upd_reg, upd_next;

    // Pipeline registers.
    logic        a_valid_reg, a_valid_next;
    wheel_err_t  a_right_reg, a_right_next;
    wheel_err_t  a_left_reg, a_left_next;
    logic        a_done_reg, a_done_next;
    logic        m_valid_reg, m_valid_next;
    logic [15:0] m_pwm_right_reg, m_pwm_left_reg;
    logic [1:0]  m_dir_right_reg, m_dir_left_reg;
    logic        m_done_reg;

    logic        out_free, a_free;
    logic        in_xfer, tick_xfer, load_xfer;
    logic        both_zero, more_cmds, advance;
    logic [CNT_W-1:0] limit;
    logic [32:0] err_right, err_left;
    logic [IDX_W-1:0] wide_index;
    logic        load_ok;
    cmd_entry_t  wr_entry, rd_entry;
    logic [ENTRY_W-1:0] rd_bits;
    logic [15:0] pwm_right, pwm_left;
    drive_cfg_t  dcfg;

    assign out_free  = !m_valid_reg || m_ready;
    assign a_free    = !a_valid_reg || out_free;
    assign s_ready   = !upd_reg && a_free;
    assign in_xfer   = s_valid && s_ready;
    assign tick_xfer = in_xfer && (s_op == OP_TICK);
    assign load_xfer = in_xfer && (s_op == OP_LOAD);

    always_comb begin
        err_right = {target_right_reg[31], target_right_reg}
                  - {s_position_right[31], s_position_right};
        err_left  = {target_left_reg[31], target_left_reg}
                  - {s_position_left[31], s_position_left};
        both_zero = (target_right_reg == s_position_right)
                 && (target_left_reg == s_position_left);
        if (CNT_W'(num_cmd_reg) > CNT_W'(COMMAND_DEPTH)) begin
            limit = CNT_W'(COMMAND_DEPTH);
        end else begin
            limit = CNT_W'(num_cmd_reg);
        end
        more_cmds = CNT_W'(ptr_reg) < limit;
        advance   = tick_xfer && both_zero && more_cmds;
    end

    // Error stage: direction and magnitude of each wheel's error, current limits.
    always_comb begin
        a_valid_next = a_valid_reg;
        a_right_next = a_right_reg;
        a_left_next  = a_left_reg;
        a_done_next  = a_done_reg;
        if (a_free) begin
            a_valid_next = tick_xfer;
            a_right_next.abs_err = err_right[32] ? (33'd0 - err_right) : err_right;
            a_left_next.abs_err  = err_left[32] ? (33'd0 - err_left) : err_left;
            a_right_next.dir = err_right[32] ? DIR_REVERSE
                             : ((err_right == 33'd0) ? DIR_OFF : DIR_FORWARD);
            a_left_next.dir  = err_left[32] ? DIR_REVERSE
                             : ((err_left == 33'd0) ? DIR_OFF : DIR_FORWARD);
            a_right_next.speed = lim_right_reg;
            a_left_next.speed  = lim_left_reg;
            a_done_next = both_zero && !more_cmds;
        end
    end

    // Table sequencing: a stepping tick reads the entry now and applies it next cycle.
    always_comb begin
        target_right_next = target_right_reg;
        target_left_next  = target_left_reg;
        lim_right_next    = lim_right_reg;
        lim_left_next     = lim_left_reg;
        ptr_next          = ptr_reg;
        upd_next          = advance;
        if (advance) begin
            ptr_next = ptr_reg + PTR_W'(1);
        end
        if (upd_reg) begin
            target_right_next = target_right_reg + rd_entry.delta_right;
            target_left_next  = target_left_reg + rd_entry.delta_left;
            lim_right_next    = rd_entry.vel_right;
            lim_left_next     = rd_entry.vel_left;
        end
    end

    always_comb begin
        wide_index           = IDX_W'(s_entry_index);
        load_ok              = load_xfer && (int'(wide_index) < COMMAND_DEPTH);
        wr_entry.delta_right = s_delta_right;
        wr_entry.delta_left  = s_delta_left;
        wr_entry.vel_right   = s_entry_speed_right;
        wr_entry.vel_left    = s_entry_speed_left;
        rd_entry             = cmd_entry_t'(rd_bits);
    end

    tws_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (COMMAND_DEPTH)
    ) u_cmd_table (
        .aclk  (aclk),
        .we    (load_ok),
        .waddr (wide_index[CMD_AW-1:0]),
        .wdata (wr_entry),
        .re    (advance),
        .raddr (ptr_reg[CMD_AW-1:0]),
        .rdata (rd_bits)
    );

    // Drive stage.
    assign dcfg.gain      = gain_reg;
    assign dcfg.speed_cap = speed_cap_reg;

    tws_drive u_drive_right (
        .err      (a_right_reg),
        .cfg      (dcfg),
        .base_pwm (base_right_reg),
        .pwm      (pwm_right)
    );

    tws_drive u_drive_left (
        .err      (a_left_reg),
        .cfg      (dcfg),
        .base_pwm (base_left_reg),
        .pwm      (pwm_left)
    );

    assign m_valid_next = out_free ? a_valid_reg : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_right_reg <= '0;
            target_left_reg  <= '0;
            lim_right_reg    <= '0;
            lim_left_reg     <= '0;
            ptr_reg          <= '0;
            upd_reg          <= 1'b0;
            a_valid_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            target_right_reg <= target_right_next;
            target_left_reg  <= target_left_next;
            lim_right_reg    <= lim_right_next;
            lim_left_reg     <= lim_left_next;
            ptr_reg          <= ptr_next;
            upd_reg          <= upd_next;
            a_valid_reg      <= a_valid_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_right_reg <= a_right_next;
        a_left_reg  <= a_left_next;
        a_done_reg  <= a_done_next;
        if (out_free) begin
            m_pwm_right_reg <= pwm_right;
            m_pwm_left_reg  <= pwm_left;
            m_dir_right_reg <= a_right_reg.dir;
            m_dir_left_reg  <= a_left_reg.dir;
            m_done_reg      <= a_done_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pwm_right     = m_pwm_right_reg;
    assign m_pwm_left      = m_pwm_left_reg;
    assign m_dir_right     = m_dir_right_reg;
    assign m_dir_left      = m_dir_left_reg;
    assign m_sequence_done = m_done_reg;

endmodule
